>>> sv/assert_macros.svh
// Assertion macros shared by the cache RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define FWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define FWC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/fwc_pkg.sv
// Package for the four-way write-back cache: state type, control structs, byte mask.
// No dependencies.
`timescale 1ns / 1ps
package fwc_pkg;

  localparam int WAYS     = 4;
  localparam int WAY_BITS = 2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_RD
  } fwc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_in;
    logic clear_wr;
    logic sel_way;
    logic wb_step;
    logic fill_step;
    logic finish;
  } fwc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic hit;
    logic dirty;
    logic cnt_done;
    logic out_busy;
  } fwc_sts_t;

  function automatic logic [31:0] strobe_mask(input logic [3:0] strobe);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      if (strobe[b]) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

>>> sv/fwc_in_if.sv
// Access channel: valid/ready plus one load or store request word.
// Depends on nothing.
`timescale 1ns / 1ps
interface fwc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] byte_addr;
  logic [3:0]  byte_strobe;
  logic [31:0] write_word;

  modport source (output valid, action, byte_addr, byte_strobe, write_word, input ready);
  modport sink   (input valid, action, byte_addr, byte_strobe, write_word, output ready);
endinterface

>>> sv/fwc_out_if.sv
// Result channel: valid/ready plus read word and hit/writeback flags.
// Depends on nothing.
`timescale 1ns / 1ps
interface fwc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_word;
  logic        was_hit;
  logic        did_writeback;

  modport source (output valid, read_word, was_hit, did_writeback, input ready);
  modport sink   (input valid, read_word, was_hit, did_writeback, output ready);
endinterface

>>> sv/fwc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module fwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/fwc_ctrl.sv
// Cache controller FSM: clear pass, lookup, writeback, refill, access, respond.
// Depends on fwc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fwc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  fwc_pkg::fwc_sts_t sts,
  output fwc_pkg::fwc_cmd_t cmd
);
  import fwc_pkg::*;

  fwc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: begin
        if (sts.hit)        state_nxt = ST_RD;
        else if (sts.dirty) state_nxt = ST_WB;
        else                state_nxt = ST_FILL;
      end
      ST_WB:     if (sts.cnt_done) state_nxt = ST_FILL;
      ST_FILL:   if (sts.cnt_done) state_nxt = ST_ACCESS;
      ST_ACCESS: state_nxt = ST_RD;
      ST_RD:     if (!sts.out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.take_in = in_valid;
      end
      ST_LOOKUP: cmd.sel_way = 1'b1;
      ST_WB:     cmd.wb_step = 1'b1;
      ST_FILL:   cmd.fill_step = 1'b1;
      ST_ACCESS: ;
      ST_RD:     cmd.finish = !sts.out_busy;
      default:   ;
    endcase
  end

  `FWC_ASSERT_NEXT(a_wb_then_fill, state_r == ST_WB && sts.cnt_done, state_r == ST_FILL, "writeback must be followed by refill")
  `FWC_ASSERT_NEXT(a_fill_then_access, state_r == ST_FILL && sts.cnt_done, state_r == ST_ACCESS, "refill must be followed by access")
  `FWC_ASSERT_NEXT(a_clear_once, state_r != ST_CLEAR, state_r != ST_CLEAR, "clear pass re-entered without reset")
endmodule

>>> sv/fwc_dp.sv
// Cache datapath: tag/line/backing RAMs, valid and dirty bits, way select, result register.
// Depends on fwc_pkg, fwc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fwc_dp #(
  parameter int LINE_OFFSET_BITS = 4,
  parameter int SET_INDEX_BITS   = 4,
  parameter int MEM_ADDR_BITS    = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fwc_pkg::fwc_cmd_t cmd,
  output fwc_pkg::fwc_sts_t sts,
  input  logic              in_action,
  input  logic [15:0]       in_byte_addr,
  input  logic [3:0]        in_byte_strobe,
  input  logic [31:0]       in_write_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_read_word,
  output logic              out_was_hit,
  output logic              out_did_writeback
);
  import fwc_pkg::*;

  localparam int WB_BITS   = LINE_OFFSET_BITS - 2;
  localparam int WPL       = 1 << WB_BITS;
  localparam int SETS      = 1 << SET_INDEX_BITS;
  localparam int TAG_W     = MEM_ADDR_BITS - LINE_OFFSET_BITS - SET_INDEX_BITS;
  localparam int MEM_AW    = MEM_ADDR_BITS - 2;
  localparam int LINE_AW   = SET_INDEX_BITS + WAY_BITS + WB_BITS;

  // input word
  logic                     act_r;
  logic [MEM_ADDR_BITS-1:0] addr_r;
  logic [3:0]               strobe_r;
  logic [31:0]              wdata_r;

  logic [MEM_ADDR_BITS-1:0]  addr_in;
  logic [SET_INDEX_BITS-1:0] set_in, set_a;
  logic [TAG_W-1:0]          tag_a;
  logic [WB_BITS-1:0]        word_a;

  assign addr_in = MEM_ADDR_BITS'(in_byte_addr);
  assign set_in  = addr_in[LINE_OFFSET_BITS +: SET_INDEX_BITS];
  assign set_a   = addr_r[LINE_OFFSET_BITS +: SET_INDEX_BITS];
  assign tag_a   = addr_r[MEM_ADDR_BITS-1 -: TAG_W];
  assign word_a  = addr_r[2 +: WB_BITS];

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      act_r    <= in_action;
      addr_r   <= addr_in;
      strobe_r <= in_byte_strobe;
      wdata_r  <= in_write_word;
    end
  end

  // valid / dirty bits per set and way
  logic [SETS-1:0][WAYS-1:0] valid_r, dirty_r;
  logic [WAYS-1:0]           vset;
  assign vset = valid_r[set_a];

  // tag RAMs, one per way; an invalid way's tag was never written and reads as zero
  logic [TAG_W-1:0] tag_q [WAYS];
  logic [TAG_W-1:0] etag  [WAYS];
  logic             fill_done;
  logic [WAY_BITS-1:0] way_r, way_c;

  for (genvar g = 0; g < WAYS; g++) begin : g_tag
    fwc_ram #(.WIDTH(TAG_W), .DEPTH(SETS)) u_tag (
      .clk   (clk),
      .we    (fill_done && way_r == WAY_BITS'(g)),
      .waddr (set_a),
      .wdata (tag_a),
      .raddr (set_in),
      .rdata (tag_q[g])
    );
    assign etag[g] = vset[g] ? tag_q[g] : '0;
  end

  // way selection: first tag match, else first free way, else low tag bits
  logic                found, free, hit_c;
  logic [WAY_BITS-1:0] match_way, free_way;

  always_comb begin
    found     = 1'b0;
    free      = 1'b0;
    match_way = '0;
    free_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (etag[w] == tag_a) begin
        found     = 1'b1;
        match_way = WAY_BITS'(w);
      end
      if (!vset[w]) begin
        free     = 1'b1;
        free_way = WAY_BITS'(w);
      end
    end
    if (found)     way_c = match_way;
    else if (free) way_c = free_way;
    else           way_c = WAY_BITS'(tag_a);
    hit_c = found && vset[match_way];
  end

  logic             hit_r, wb_r;
  logic [TAG_W-1:0] vtag_r;

  always_ff @(posedge clk) begin
    if (cmd.sel_way) begin
      way_r  <= way_c;
      hit_r  <= hit_c;
      vtag_r <= etag[way_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_way)      wb_r <= 1'b0;
    else if (cmd.wb_step) wb_r <= 1'b1;
  end

  // line word stepping for writeback and refill; each write follows its read in the next cycle
  logic [WB_BITS:0]   cnt_r;
  logic [WB_BITS-1:0] idx, widx_r;
  logic               step, cnt_done, pend_r;

  assign step      = cmd.wb_step || cmd.fill_step;
  assign idx       = cnt_r[WB_BITS-1:0];
  assign cnt_done  = cnt_r == (WB_BITS+1)'(WPL);
  assign fill_done = cmd.fill_step && cnt_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= step && !cnt_done;
      if (cmd.sel_way || (step && cnt_done)) cnt_r <= '0;
      else if (step)                         cnt_r <= cnt_r + 1'b1;
    end
    widx_r <= idx;
  end

  // backing memory clear pass after reset
  logic [MEM_AW-1:0] clr_idx_r;
  logic              clear_done;
  assign clear_done = &clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            clr_idx_r <= '0;
    else if (cmd.clear_wr) clr_idx_r <= clr_idx_r + 1'b1;
  end

  // line RAM
  logic [31:0]         line_q, back_q, merged;
  logic [WAY_BITS-1:0] way_rd;
  logic                line_we;
  logic [LINE_AW-1:0]  line_waddr, line_raddr;
  logic [31:0]         line_wdata;
  logic                back_we;
  logic [MEM_AW-1:0]   back_waddr, back_raddr;
  logic [31:0]         back_wdata;

  assign way_rd     = cmd.sel_way ? way_c : way_r;
  assign line_raddr = {set_a, way_rd, cmd.wb_step ? idx : word_a};

  always_comb begin
    merged = line_q;
    if (act_r) merged = (line_q & ~strobe_mask(strobe_r)) | (wdata_r & strobe_mask(strobe_r));
  end

  always_comb begin
    line_we    = 1'b0;
    line_waddr = {set_a, way_r, widx_r};
    line_wdata = back_q;
    if (pend_r && cmd.fill_step) begin
      line_we = 1'b1;
    end else if (cmd.finish && act_r) begin
      line_we    = 1'b1;
      line_waddr = {set_a, way_r, word_a};
      line_wdata = merged;
    end
  end

  fwc_ram #(.WIDTH(32), .DEPTH(SETS * WAYS * WPL)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (line_wdata),
    .raddr (line_raddr),
    .rdata (line_q)
  );

  // backing memory
  assign back_raddr = {addr_r[MEM_ADDR_BITS-1:LINE_OFFSET_BITS], idx};

  always_comb begin
    back_we    = 1'b0;
    back_waddr = {vtag_r, set_a, widx_r};
    back_wdata = line_q;
    if (cmd.clear_wr) begin
      back_we    = 1'b1;
      back_waddr = clr_idx_r;
      back_wdata = '0;
    end else if (pend_r && cmd.wb_step) begin
      back_we = 1'b1;
    end
  end

  fwc_ram #(.WIDTH(32), .DEPTH(1 << MEM_AW)) u_back (
    .clk   (clk),
    .we    (back_we),
    .waddr (back_waddr),
    .wdata (back_wdata),
    .raddr (back_raddr),
    .rdata (back_q)
  );

  // valid / dirty update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (fill_done) begin
        valid_r[set_a][way_r] <= 1'b1;
        dirty_r[set_a][way_r] <= 1'b0;
      end
      if (cmd.finish && act_r) dirty_r[set_a][way_r] <= 1'b1;
    end
  end

  // result register
  logic        out_valid_r;
  logic [31:0] rword_r;
  logic        ohit_r, owb_r;

  always_ff @(posedge clk) begin
    if (!rst_n)            out_valid_r <= 1'b0;
    else if (cmd.finish)   out_valid_r <= 1'b1;
    else if (out_ready)    out_valid_r <= 1'b0;
    if (cmd.finish) begin
      rword_r <= merged;
      ohit_r  <= hit_r;
      owb_r   <= wb_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_word     = rword_r;
  assign out_was_hit       = ohit_r;
  assign out_did_writeback = owb_r;

  assign sts.clear_done = clear_done;
  assign sts.hit        = hit_c;
  assign sts.dirty      = dirty_r[set_a][way_c];
  assign sts.cnt_done   = cnt_done;
  assign sts.out_busy   = out_valid_r && !out_ready;

  `FWC_ASSERT(a_dirty_valid, (dirty_r & ~valid_r) == '0, "dirty line that is not valid")
endmodule

>>> sv/four_way_write_back_cache_unit.sv
// Top level of the four-way write-back cache: controller plus datapath.
// Depends on fwc_pkg, fwc_in_if, fwc_out_if, fwc_ctrl, fwc_dp.
//
//   channel | dir | handshake   | word
//   in_ch   | in  | valid/ready | action, byte_addr, byte_strobe, write_word
//   out_ch  | out | valid/ready | read_word, was_hit, did_writeback
//
// Hit: accept, tag lookup, then line read and merge; a new access is accepted only after that.
// Miss: adds a refill and an access step, and before the refill a writeback when the victim is
// dirty; one line word moves per cycle over the RAM ports.
// After reset the backing memory is zeroed with in_ch.ready low.
// The result register holds a word until taken; the next access may be accepted meanwhile.
`timescale 1ns / 1ps
module four_way_write_back_cache_unit #(
  parameter int LINE_OFFSET_BITS = 4,
  parameter int SET_INDEX_BITS   = 4,
  parameter int MEM_ADDR_BITS    = 16
) (
  input logic      clk,
  input logic      rst_n,
  fwc_in_if.sink   in_ch,
  fwc_out_if.source out_ch
);
  import fwc_pkg::*;

  fwc_cmd_t cmd;
  fwc_sts_t sts;

  fwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwc_dp #(
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
    .SET_INDEX_BITS   (SET_INDEX_BITS),
    .MEM_ADDR_BITS    (MEM_ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_action         (in_ch.action),
    .in_byte_addr      (in_ch.byte_addr),
    .in_byte_strobe    (in_ch.byte_strobe),
    .in_write_word     (in_ch.write_word),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_read_word     (out_ch.read_word),
    .out_was_hit       (out_ch.was_hit),
    .out_did_writeback (out_ch.did_writeback)
  );
endmodule

>>> dv/fwc_tb_if.sv
// Testbench-side copies of the cache channels are not needed; this file holds
// the simple clock-free helpers shared by the testbench. Depends on nothing.
`timescale 1ns / 1ps
package fwc_tb_pkg;
  typedef struct packed {
    logic        action;
    logic [15:0] byte_addr;
    logic [3:0]  byte_strobe;
    logic [31:0] write_word;
  } access_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic        was_hit;
    logic        did_writeback;
  } reply_t;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_STORE = 1'b1;
endpackage

>>> dv/four_way_write_back_cache_unit_tb.sv
// Testbench for the four-way write-back cache: directed table then random
// accesses, each reply checked against a cache/memory predictor.
// Depends on fwc_pkg, fwc_in_if, fwc_out_if, fwc_tb_pkg and the cache RTL.
`timescale 1ns / 1ps
module four_way_write_back_cache_unit_tb;
  import fwc_tb_pkg::*;

  localparam int OFFS = 4, SETB = 4, MEMB = 16;
  localparam int WPL = 1 << (OFFS - 2);
  localparam int NSET = 1 << SETB;
  localparam int TAGB = MEMB - OFFS - SETB;

  logic clk, rst_n;
  fwc_in_if  in_ch();
  fwc_out_if out_ch();

  four_way_write_back_cache_unit #(.LINE_OFFSET_BITS(OFFS), .SET_INDEX_BITS(SETB),
    .MEM_ADDR_BITS(MEMB)) u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // predictor state
  logic [31:0]     pm_line [NSET][4][WPL];
  logic [TAGB-1:0] pm_tag [NSET][4];
  logic            pm_valid [NSET][4];
  logic            pm_dirty [NSET][4];
  logic [31:0]     pm_mem [1 << (MEMB - 2)];

  reply_t pending_replies[$];
  int mismatches = 0;
  bit stim_done = 0;
  bit hold_rx = 0;
  bit quiet_gaps = 0;

  function automatic logic [31:0] byte_mask(logic [3:0] s);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) if (s[b]) m[8*b +: 8] = 8'hFF;
    return m;
  endfunction

  function automatic reply_t cache_access(access_t a);
    logic [TAGB-1:0] tg;
    int st, wd, wy;
    bit found, hit;
    reply_t r;
    logic [31:0] m;
    tg = a.byte_addr[MEMB-1 -: TAGB];
    st = a.byte_addr[OFFS +: SETB];
    wd = a.byte_addr[2 +: OFFS-2];
    found = 0; wy = 0; r.did_writeback = 0;
    for (int w = 0; w < 4; w++) if (!found && pm_tag[st][w] == tg) begin
      wy = w; found = 1;
    end
    if (!found) begin
      wy = -1;
      for (int w = 0; w < 4; w++) if (wy < 0 && !pm_valid[st][w]) wy = w;
      if (wy < 0) wy = tg[1:0];
    end
    hit = found && pm_valid[st][wy];
    if (!hit) begin
      if (pm_dirty[st][wy]) begin
        for (int w = 0; w < WPL; w++)
          pm_mem[{pm_tag[st][wy], st[SETB-1:0], w[OFFS-3:0]}] = pm_line[st][wy][w];
        pm_dirty[st][wy] = 0;
        r.did_writeback = 1;
      end
      for (int w = 0; w < WPL; w++)
        pm_line[st][wy][w] = pm_mem[{a.byte_addr[MEMB-1:OFFS], w[OFFS-3:0]}];
      pm_valid[st][wy] = 1;
      pm_tag[st][wy] = tg;
    end
    r.read_word = pm_line[st][wy][wd];
    if (a.action == ACT_STORE) begin
      m = byte_mask(a.byte_strobe);
      r.read_word = (r.read_word & ~m) | (a.write_word & m);
      pm_line[st][wy][wd] = r.read_word;
      pm_dirty[st][wy] = 1;
    end
    r.was_hit = hit;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // directed rows; check_fixed marks rows whose reply is typed in
  typedef struct {
    access_t a;
    bit      check_fixed;
    reply_t  r;
  } row_t;
  row_t dir_rows[$];

  task automatic add_row(logic act, logic [15:0] ad, logic [3:0] sb, logic [31:0] wd,
                         bit fx = 0, logic [31:0] rw = 0, logic h = 0, logic wb = 0);
    row_t t;
    t.a = '{act, ad, sb, wd};
    t.check_fixed = fx;
    t.r = '{rw, h, wb};
    dir_rows.push_back(t);
  endtask

  // valid stays high after an accept so words can follow back to back
  task automatic send_word(access_t a);
    reply_t r;
    if (!quiet_gaps) begin
      while ($urandom_range(99) < 22) begin
        in_ch.valid <= 0;
        @(posedge clk);
      end
    end
    r = cache_access(a);
    pending_replies.push_back(r);
    in_ch.valid <= 1;
    {in_ch.action, in_ch.byte_addr, in_ch.byte_strobe, in_ch.write_word} <= a;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic access_t rand_access(int hot_tags);
    access_t a;
    a.action = 1'($urandom_range(1));
    a.byte_addr = 16'($urandom);
    // keep most tags in a small pool so sets fill, hit and evict
    if (hot_tags) a.byte_addr[15:8] = 8'($urandom_range(7)) | ($urandom_range(1) ? 8'h0 : 8'hF8);
    a.byte_strobe = 4'($urandom);
    a.write_word = $urandom;
    return a;
  endfunction

  initial begin
    access_t a;
    in_ch.valid = 0; in_ch.action = 0; in_ch.byte_addr = 0;
    in_ch.byte_strobe = 0; in_ch.write_word = 0;
    for (int s = 0; s < NSET; s++)
      for (int w = 0; w < 4; w++) begin
        pm_tag[s][w] = 0; pm_valid[s][w] = 0; pm_dirty[s][w] = 0;
        for (int k = 0; k < WPL; k++) pm_line[s][w][k] = 0;
      end
    foreach (pm_mem[i]) pm_mem[i] = 0;
    rst_n = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    // tag 0 matches invalid way 0 after reset: miss, refill of zeros
    add_row(ACT_LOAD, 16'h0000, 4'h0, 32'h0, 1, 32'h0, 0, 0);
    add_row(ACT_STORE, 16'h0004, 4'hF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 0);
    add_row(ACT_STORE, 16'h0004, 4'h0, 32'h1234_5678, 1, 32'hFFFF_FFFF, 1, 0);
    add_row(ACT_STORE, 16'h0008, 4'h5, 32'hA5A5_A5A5, 1, 32'h00A5_00A5, 1, 0);
    add_row(ACT_STORE, 16'h000B, 4'hA, 32'h5A5A_5A5A, 1, 32'h5AA5_5AA5, 1, 0);
    add_row(ACT_STORE, 16'hFFFF, 4'hF, 32'hDEAD_BEEF, 1, 32'hDEAD_BEEF, 0, 0);
    add_row(ACT_LOAD, 16'hFFFC, 4'hF, 32'h0, 1, 32'hDEAD_BEEF, 1, 0);
    // fill set 0 with tags 1..4, forcing eviction of dirty tag 0 line
    for (int t = 1; t <= 4; t++) add_row(ACT_STORE, 16'(t << 8), 4'h3, 32'(32'h0101_0000 * t));
    add_row(ACT_LOAD, 16'h0004, 4'h0, 32'h0);
    add_row(ACT_LOAD, 16'h0008, 4'h0, 32'h0);
    for (int t = 5; t <= 9; t++) add_row(ACT_LOAD, 16'(t << 8) | 16'h0C, 4'hF, 32'h0);
    add_row(ACT_STORE, 16'h0100, 4'hC, 32'hCAFE_F00D);
    add_row(ACT_LOAD, 16'h0100, 4'h0, 32'h0);

    for (int i = 0; i < dir_rows.size(); i++) begin
      send_word(dir_rows[i].a);
      if (dir_rows[i].check_fixed && pending_replies[$] !== dir_rows[i].r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: typed reply %h, predicted %h", i, dir_rows[i].r,
                   pending_replies[$]);
      end
    end

    for (int i = 0; i < 1000; i++) begin
      if (i == 300) hold_rx = 1;
      if (i >= 500 && i < 600) quiet_gaps = 1; else quiet_gaps = 0;
      a = rand_access($urandom_range(99) < 85);
      send_word(a);
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  // receiver: random stalls, one long hold while the sender keeps offering
  initial begin
    int n;
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ch.ready <= 0;
        hold_rx = 0;
        for (n = 0; n < 400; n++) @(posedge clk);
      end
      out_ch.ready <= quiet_gaps || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.read_word, out_ch.was_hit, out_ch.did_writeback};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("reply with none pending: %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got.read_word !== want.read_word || got.was_hit !== want.was_hit ||
            got.did_writeback !== want.did_writeback) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: word %h/%h hit %b/%b wb %b/%b", want.read_word,
                     got.read_word, want.was_hit, got.was_hit, want.did_writeback,
                     got.did_writeback);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
